/* hdl/pollard_rho_dlog_walk_unit_assert.svh */
// Assertion macros shared by the walk unit.
`ifndef POLLARD_RHO_DLOG_WALK_UNIT_ASSERT_SVH
`define POLLARD_RHO_DLOG_WALK_UNIT_ASSERT_SVH

// An implication checked on every clock edge outside reset.
`define PRW_ASSERT_IMP(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// A condition that must hold on every clock edge outside reset.
`define PRW_ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`endif

/* hdl/prw_pkg.sv */
`timescale 1ns / 1ps
package prw_pkg;

  localparam int unsigned DefWidth      = 64;
  localparam int unsigned DefCountWidth = 32;
  localparam int unsigned LimitWidth    = 32;
  localparam int unsigned CfgIdxWidth   = 2;

  localparam logic [CfgIdxWidth-1:0] REG_MODULUS = 2'd0;
  localparam logic [CfgIdxWidth-1:0] REG_FIRST   = 2'd1;
  localparam logic [CfgIdxWidth-1:0] REG_SECOND  = 2'd2;
  localparam logic [CfgIdxWidth-1:0] REG_LIMIT   = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RED_Q,
    ST_RED_R,
    ST_RED_ONE,
    ST_SAVE,
    ST_STEP,
    ST_MUL,
    ST_CHECK,
    ST_DONE
  } state_t;

  // Operation handed to the modular multiplier.
  typedef enum logic [1:0] {
    MUL_X_Q,
    MUL_X_X,
    MUL_X_R,
    MUL_RED
  } mul_op_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } mul_ctrl_t;

endpackage

/* hdl/prw_modmul.sv */
`timescale 1ns / 1ps
// Bit-serial modular multiplier: one multiplier bit per cycle, most
// significant first, by double and conditional add. A zero modulus stands
// for 2^WIDTH and the sums simply wrap.
module prw_modmul
  import prw_pkg::*;
#(
  parameter int unsigned WIDTH = DefWidth
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] op_a,
  input  logic [WIDTH-1:0] op_b,
  input  logic [WIDTH-1:0] modulus,
  output mul_ctrl_t        ctrl,
  output logic [WIDTH-1:0] product
);

  localparam int unsigned CntW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] acc;
  logic [WIDTH-1:0] mult_a;
  logic [WIDTH-1:0] shreg;
  logic [WIDTH-1:0] modv;
  logic [CntW-1:0]  cnt;
  logic             busy;
  logic             done;
  logic [WIDTH-1:0] dbl;
  logic [WIDTH-1:0] acc_next;

  function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] x,
                                               input logic [WIDTH-1:0] y,
                                               input logic [WIDTH-1:0] m);
    logic [WIDTH:0] s;
    logic [WIDTH:0] d;
    begin
      s = {1'b0, x} + {1'b0, y};
      d = s - {1'b0, m};
      if (m == '0) begin
        add_mod = s[WIDTH-1:0];
      end else if (s >= {1'b0, m}) begin
        add_mod = d[WIDTH-1:0];
      end else begin
        add_mod = s[WIDTH-1:0];
      end
    end
  endfunction

  always_comb begin
    dbl      = add_mod(acc, acc, modv);
    acc_next = shreg[WIDTH-1] ? add_mod(dbl, mult_a, modv) : dbl;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy   <= 1'b1;
        cnt    <= CntW'(WIDTH);
        acc    <= '0;
        mult_a <= op_a;
        shreg  <= op_b;
        modv   <= modulus;
      end else if (busy) begin
        acc   <= acc_next;
        shreg <= {shreg[WIDTH-2:0], 1'b0};
        cnt   <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign product    = acc;
  assign ctrl.start = start;
  assign ctrl.busy  = busy;
  assign ctrl.done  = done;

endmodule

/* hdl/pollard_rho_dlog_walk_unit.sv */
`timescale 1ns / 1ps
// Channel   | handshake           | payload
// ----------+---------------------+-------------------------------------------
// request   | in_valid / in_stall | base_q, base_r, group_order
// result    | out_valid/out_stall | exp_m, exp_n, step_count, gave_up
// config    | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// Each walk step is paced by the bit-serial multiplier, which handles one
// multiplier bit a cycle. A job first reduces q, r and 1 by multiplication
// with one (three products), then runs up to the limit. Reset is synchronous
// and active high; it clears control state and sets the registers to their
// reset values. One job is worked at a time; the result register holds its
// result while out_stall is high, and a new request is taken only once that
// result has gone.
module pollard_rho_dlog_walk_unit
  import prw_pkg::*;
#(
  parameter int unsigned WIDTH       = DefWidth,
  parameter int unsigned COUNT_WIDTH = DefCountWidth
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [WIDTH-1:0]       base_q,
  input  logic [WIDTH-1:0]       base_r,
  input  logic [WIDTH-1:0]       group_order,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [WIDTH-1:0]       exp_m,
  output logic [WIDTH-1:0]       exp_n,
  output logic [COUNT_WIDTH-1:0] step_count,
  output logic                   gave_up,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CfgIdxWidth-1:0] cfg_index,
  input  logic [WIDTH-1:0]       cfg_data
);

`include "pollard_rho_dlog_walk_unit_assert.svh"

  // Configuration registers.
  logic [WIDTH-1:0]      modulus;
  logic [WIDTH-1:0]      first_split;
  logic [WIDTH-1:0]      second_split;
  logic [LimitWidth-1:0] iteration_limit;

  // Job state.
  state_t                 state;
  state_t                 state_next;
  logic [WIDTH-1:0]       q;
  logic [WIDTH-1:0]       r;
  logic [WIDTH-1:0]       ord;
  logic [WIDTH-1:0]       one_o;
  logic [WIDTH-1:0]       wx;
  logic [WIDTH-1:0]       wa;
  logic [WIDTH-1:0]       wb;
  logic [WIDTH-1:0]       sx;
  logic [WIDTH-1:0]       sa;
  logic [WIDTH-1:0]       sb;
  logic [COUNT_WIDTH-1:0] steps;
  logic [COUNT_WIDTH-1:0] limit;
  logic [COUNT_WIDTH:0]   span;
  logic [COUNT_WIDTH:0]   span_cnt;
  mul_op_t                op;

  // Multiplier hookup.
  logic             mul_start;
  logic [WIDTH-1:0] mul_a;
  logic [WIDTH-1:0] mul_b;
  logic [WIDTH-1:0] mul_p;
  mul_ctrl_t        mul_ctrl;
  logic [WIDTH-1:0] product;

  logic in_take;
  logic out_take;
  logic at_limit;
  logic step_ok;

  // Modular add of reduced operands; a zero modulus wraps.
  function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] x,
                                               input logic [WIDTH-1:0] y,
                                               input logic [WIDTH-1:0] m);
    logic [WIDTH:0] s;
    logic [WIDTH:0] d;
    begin
      s = {1'b0, x} + {1'b0, y};
      d = s - {1'b0, m};
      if (m == '0) begin
        add_mod = s[WIDTH-1:0];
      end else if (s >= {1'b0, m}) begin
        add_mod = d[WIDTH-1:0];
      end else begin
        add_mod = s[WIDTH-1:0];
      end
    end
  endfunction

  function automatic logic [WIDTH-1:0] sub_mod(input logic [WIDTH-1:0] x,
                                               input logic [WIDTH-1:0] y,
                                               input logic [WIDTH-1:0] m);
    begin
      if (m == '0 || x >= y) begin
        sub_mod = x - y;
      end else begin
        sub_mod = x + (m - y);
      end
    end
  endfunction

  assign in_take   = in_valid && !in_stall;
  assign out_take  = out_valid && !out_stall;
  assign in_stall  = (state != ST_IDLE) || out_valid;
  assign cfg_ready = (state == ST_IDLE);
  assign at_limit  = (steps >= limit);

  // The partition of the current walk point picks the step.
  always_comb begin
    if (wx < first_split) begin
      op = MUL_X_Q;
    end else if (wx < second_split) begin
      op = MUL_X_X;
    end else begin
      op = MUL_X_R;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus         <= WIDTH'(3);
      first_split     <= WIDTH'(1);
      second_split    <= WIDTH'(2);
      iteration_limit <= '1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MODULUS: modulus         <= cfg_data;
        REG_FIRST:   first_split     <= cfg_data;
        REG_SECOND:  second_split    <= cfg_data;
        REG_LIMIT:   iteration_limit <= LimitWidth'({{64{1'b0}}, cfg_data});
        default:     ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (in_take) state_next = ST_RED_Q;
      ST_RED_Q:   if (mul_ctrl.done) state_next = ST_RED_R;
      ST_RED_R:   if (mul_ctrl.done) state_next = ST_RED_ONE;
      ST_RED_ONE: if (mul_ctrl.done) state_next = ST_SAVE;
      ST_SAVE:    state_next = at_limit ? ST_DONE : ST_STEP;
      ST_STEP:    state_next = ST_MUL;
      ST_MUL:     if (mul_ctrl.done) state_next = ST_CHECK;
      ST_CHECK: begin
        if (wx == sx || at_limit) begin
          state_next = ST_DONE;
        end else if (span_cnt == span) begin
          state_next = ST_SAVE;
        end else begin
          state_next = ST_STEP;
        end
      end
      ST_DONE:    state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // Multiplier operands follow the state. For a reduction the value to be
  // reduced is the serial multiplier, so every partial sum stays reduced.
  always_comb begin
    mul_start = 1'b0;
    mul_a     = wx;
    mul_b     = wx;
    mul_p     = modulus;
    case (state)
      ST_RED_Q:   begin mul_a = WIDTH'(1); mul_b = q; mul_start = !mul_ctrl.busy; end
      ST_RED_R:   begin mul_a = WIDTH'(1); mul_b = r; mul_start = !mul_ctrl.busy; end
      ST_RED_ONE: begin mul_a = WIDTH'(1); mul_b = WIDTH'(1); mul_p = ord;
                        mul_start = !mul_ctrl.busy; end
      ST_STEP: begin
        mul_start = 1'b1;
        case (op)
          MUL_X_Q: mul_b = q;
          MUL_X_R: mul_b = r;
          default: mul_b = wx;
        endcase
      end
      default: ;
    endcase
  end

  // A start pulse in the reduction states is taken only once: the multiplier
  // goes busy and ignores start until done, and done moves the state on.
  assign step_ok = 1'b1;

  prw_modmul #(
    .WIDTH(WIDTH)
  ) u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start && !(mul_ctrl.done)),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .modulus(mul_p),
    .ctrl   (mul_ctrl),
    .product(product)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_take) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_take) begin
            q     <= base_q;
            r     <= base_r;
            ord   <= group_order;
            wa    <= '0;
            wb    <= '0;
            span  <= (COUNT_WIDTH + 1)'(1);
            steps <= '0;
            if (COUNT_WIDTH >= LimitWidth) begin
              limit <= COUNT_WIDTH'(iteration_limit);
            end else if (iteration_limit > LimitWidth'({COUNT_WIDTH{1'b1}})) begin
              limit <= '1;
            end else begin
              limit <= COUNT_WIDTH'(iteration_limit);
            end
          end
        end
        ST_RED_Q:   if (mul_ctrl.done) q <= product;
        ST_RED_R:   if (mul_ctrl.done) r <= product;
        ST_RED_ONE: if (mul_ctrl.done && step_ok) begin
          one_o <= product;
          // The start value 1 reduced by the group modulus.
          wx    <= (modulus == WIDTH'(1)) ? '0 : WIDTH'(1);
        end
        ST_SAVE: begin
          sx       <= wx;
          sa       <= wa;
          sb       <= wb;
          span     <= {span[COUNT_WIDTH-1:0], 1'b0};
          span_cnt <= '0;
        end
        ST_STEP: begin
          steps    <= steps + 1'b1;
          span_cnt <= span_cnt + 1'b1;
          case (op)
            MUL_X_Q: begin
              wa <= add_mod(wa, one_o, ord);
            end
            MUL_X_X: begin
              wa <= add_mod(wa, wa, ord);
              wb <= add_mod(wb, wb, ord);
            end
            default: begin
              wb <= add_mod(wb, one_o, ord);
            end
          endcase
        end
        ST_MUL: if (mul_ctrl.done) wx <= product;
        ST_DONE: begin
          out_valid <= 1'b1;
          if (wx == sx && steps != '0) begin
            exp_m   <= sub_mod(sa, wa, ord);
            exp_n   <= sub_mod(wb, sb, ord);
            gave_up <= 1'b0;
          end else begin
            exp_m   <= '0;
            exp_n   <= '0;
            gave_up <= 1'b1;
          end
          step_count <= steps;
        end
        default: ;
      endcase
    end
  end

  // The step count never passes the effective limit while walking.
  `PRW_ASSERT_IMP(a_steps_in_limit, clk, rst, (state == ST_CHECK), (steps <= limit),
                  "step count passed the limit")
  // A result and a running job do not overlap.
  `PRW_ASSERT_IMP(a_idle_with_result, clk, rst, out_valid, (state == ST_IDLE),
                  "result pending while a job runs")
  // The multiplier finishes only while a product is awaited.
  `PRW_ASSERT_IMP(a_mul_done_owner, clk, rst, mul_ctrl.done,
                  (state == ST_MUL || state == ST_RED_Q || state == ST_RED_R ||
                   state == ST_RED_ONE), "product with no consumer")
  // Configuration is taken only between jobs.
  `PRW_ASSERT_IMP(a_cfg_idle, clk, rst, (cfg_valid && cfg_ready), (state == ST_IDLE),
                  "configuration written during a job")

endmodule
